### rtl/wsi_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and coefficient functions of the windowed sinc interpolator.
package wsi_pkg;

   // Configuration of the filter.
   localparam int INTERP_FACTOR = 16;
   localparam int HALF_TAPS     = 16;
   localparam int SAMPLE_BITS   = 16;
   localparam int TAPS          = 2 * HALF_TAPS;

   // Derived widths.
   localparam int PHASE_BITS     = $clog2(INTERP_FACTOR);
   localparam int TAP_BITS       = $clog2(TAPS);
   localparam int CNT_BITS       = $clog2(HALF_TAPS);
   localparam int COEF_BITS      = 18;
   localparam int COEF_FRAC      = 16;
   localparam int COEF_ADDR_BITS = PHASE_BITS + TAP_BITS;
   localparam int COEF_DEPTH     = 1 << COEF_ADDR_BITS;
   localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS       = PROD_BITS + TAP_BITS;
   localparam int RND_BITS       = ACC_BITS - COEF_FRAC;

   // Fixed point constants of the coefficient build.
   localparam logic [63:0] PI_Q28          = 64'd843314857;
   localparam logic [63:0] BETA_SQ_QUARTER = 64'd9;
   localparam logic [63:0] HH              = 64'(HALF_TAPS * HALF_TAPS);

   // One issued tap: sample and coefficient address for the shared MAC.
   typedef struct packed {
      logic                          valid;
      logic                          first;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [COEF_ADDR_BITS-1:0]     coef_addr;
   } mac_issue_type;

   // Status of the MAC pipeline.
   typedef struct packed {
      logic busy;
   } mac_status_type;

   // Unsigned 64-bit quotient by restoring shift and subtract, used only while
   // the coefficient constants are built.
   function automatic logic [63:0] quot64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] num;
      logic [63:0] q;
      rem = '0;
      num = n;
      q   = '0;
      for (int i = 0; i < 64; i++) begin
         rem = {rem[63:0], num[63]};
         num = num << 1;
         q   = q << 1;
         if (rem >= {1'b0, d}) begin
            rem = rem - {1'b0, d};
            q   = q | 64'd1;
         end
      end
      return q;
   endfunction

   // Modified Bessel function I0 in Q24, argument num/HH, 40 series terms.
   function automatic logic [63:0] bessel_q24(input logic [63:0] num);
      logic [63:0] term;
      logic [63:0] sum;
      term = 64'd1 << 24;
      sum  = term;
      for (int m = 1; m <= 40; m++) begin
         term = quot64(term * num, 64'(m) * 64'(m) * HH);
         sum  = sum + term;
      end
      return sum;
   endfunction

   // Sine of pi*p/INTERP_FACTOR in Q28 from a Taylor series.
   function automatic logic [63:0] sin_q28(input int p);
      int          q;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      q    = (p <= INTERP_FACTOR - p) ? p : (INTERP_FACTOR - p);
      a    = (PI_Q28 * 64'(q)) >> PHASE_BITS;
      a2   = (a * a) >> 28;
      term = a;
      pos  = a;
      neg  = '0;
      for (int m = 1; m <= 12; m++) begin
         term = quot64((term * a2) >> 28, 64'(2 * m) * 64'(2 * m + 1));
         if (m % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      return (pos > neg) ? (pos - neg) : 64'd0;
   endfunction

   localparam logic [63:0] I0_BETA = bessel_q24(BETA_SQ_QUARTER * HH);

   // Coefficient of phase p and tap j in Q16; codes outside the table read zero.
   function automatic logic signed [COEF_BITS-1:0] coef_value(input int p, input int j);
      int          k;
      int          d;
      logic [63:0] kk;
      logic [63:0] w;
      logic [63:0] s;
      logic [63:0] mag;
      logic [63:0] ad;
      logic [63:0] c;
      logic        neg;
      if (p >= INTERP_FACTOR || j >= TAPS) begin
         return '0;
      end
      k   = j - HALF_TAPS;
      kk  = 64'(k * k);
      w   = quot64(bessel_q24(BETA_SQ_QUARTER * (HH - kk)) << 28, I0_BETA);
      neg = 1'b0;
      if (p == 0) begin
         mag = (k == 0) ? (64'd1 << 28) : 64'd0;
      end else begin
         s   = sin_q28(p);
         d   = p - k * INTERP_FACTOR;
         ad  = (d < 0) ? 64'(-d) : 64'(d);
         mag = quot64((64'(INTERP_FACTOR) * s) << 28, PI_Q28 * ad);
         neg = ((k % 2) != 0) != (k >= 1);
      end
      c = (w * mag + (64'd1 << 39)) >> 40;
      return neg ? -COEF_BITS'(c) : COEF_BITS'(c);
   endfunction

endpackage

### rtl/wsi_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the input samples and the interpolated results.
interface wsi_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [wsi_pkg::SAMPLE_BITS-1:0] sample_in;
   logic                                   start_req;
   logic                                   flush;

   modport source (output valid, output sample_in, output start_req, output flush,
                   input ready);
   modport sink   (input valid, input sample_in, input start_req, input flush,
                   output ready);
endinterface

interface wsi_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [wsi_pkg::SAMPLE_BITS-1:0] value_out;
   logic [wsi_pkg::PHASE_BITS-1:0]         phase;
   logic                                   block_last;

   modport source (output valid, output value_out, output phase, output block_last,
                   input ready);
   modport sink   (input valid, input value_out, input phase, input block_last,
                   output ready);
endinterface

### rtl/windowed_sinc_interpolator.sv
`timescale 1ns / 1ps
// Top level of the windowed sinc interpolator, upsampling by sixteen.
//
//   Channel   Port      Direction  Word
//   input     req_port  sink       sample_in, start_req, flush
//   result    rsp_port  source     value_out, phase, block_last
//
// For a word that emits a centre block, each of the sixteen phases runs its 32 taps
// through the one shared multiply-accumulate unit, waits in the finish step while the
// pipeline drains and loads the output register at the end of that step. A word that
// emits nothing is taken without leaving the idle state. Reset is synchronous and
// clears history and counters at once. A stalled result holds the sequencer in its
// finish step.
module windowed_sinc_interpolator (
   input logic         clock,
   input logic         reset,
   wsi_req_if.sink     req_port,
   wsi_rsp_if.source   rsp_port
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_ISSUE  = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   localparam logic [wsi_pkg::CNT_BITS-1:0]   CNT_MAX   = wsi_pkg::CNT_BITS'(wsi_pkg::HALF_TAPS - 1);
   localparam logic [wsi_pkg::TAP_BITS-1:0]   TAP_LAST  = wsi_pkg::TAP_BITS'(wsi_pkg::TAPS - 1);
   localparam logic [wsi_pkg::PHASE_BITS-1:0] PHASE_LAST =
      wsi_pkg::PHASE_BITS'(wsi_pkg::INTERP_FACTOR - 1);
   localparam int OFS_BITS = wsi_pkg::TAP_BITS + 2;

   state_type                              state_ff;
   state_type                              state_in;
   logic signed [wsi_pkg::SAMPLE_BITS-1:0] hist_ff [wsi_pkg::TAPS];
   logic signed [wsi_pkg::SAMPLE_BITS-1:0] hist_in [wsi_pkg::TAPS];
   logic signed [wsi_pkg::SAMPLE_BITS-1:0] hist_base [wsi_pkg::TAPS];
   logic [wsi_pkg::CNT_BITS-1:0]           recv_ff;
   logic [wsi_pkg::CNT_BITS-1:0]           recv_in;
   logic [wsi_pkg::CNT_BITS-1:0]           recv_base;
   logic [wsi_pkg::CNT_BITS-1:0]           pend_ff;
   logic [wsi_pkg::CNT_BITS-1:0]           pend_in;
   logic [wsi_pkg::CNT_BITS-1:0]           pend_base;
   logic [wsi_pkg::CNT_BITS-1:0]           centre_ff;
   logic [wsi_pkg::CNT_BITS-1:0]           centre_in;
   logic [wsi_pkg::PHASE_BITS-1:0]         phase_ff;
   logic [wsi_pkg::PHASE_BITS-1:0]         phase_in;
   logic [wsi_pkg::TAP_BITS-1:0]           tap_ff;
   logic [wsi_pkg::TAP_BITS-1:0]           tap_in;
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic signed [wsi_pkg::SAMPLE_BITS-1:0] rsp_value_ff;
   logic [wsi_pkg::PHASE_BITS-1:0]         rsp_phase_ff;
   logic                                   rsp_last_ff;
   logic                                   req_accept;
   logic                                   push;
   logic                                   emit;
   logic                                   rsp_load;
   logic [OFS_BITS-1:0]                    ofs;
   logic signed [wsi_pkg::SAMPLE_BITS-1:0] tap_sample;
   logic signed [wsi_pkg::SAMPLE_BITS-1:0] push_value;
   logic signed [wsi_pkg::SAMPLE_BITS-1:0] mac_result;
   wsi_pkg::mac_issue_type                 issue;
   wsi_pkg::mac_status_type                mac_status;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_port.valid & req_port.ready;

   // Input word: optional clear, then push and counter update; a flush with nothing pending pushes nothing.
   always_comb begin
      for (int i = 0; i < wsi_pkg::TAPS; i++) begin
         hist_base[i] = req_port.start_req ? '0 : hist_ff[i];
      end
      recv_base  = req_port.start_req ? '0 : recv_ff;
      pend_base  = req_port.start_req ? '0 : pend_ff;
      push       = 1'b0;
      emit       = 1'b0;
      push_value = '0;
      recv_in    = recv_base;
      pend_in    = pend_base;
      centre_in  = CNT_MAX;
      if (req_port.flush) begin
         if (pend_base != '0) begin
            push      = 1'b1;
            emit      = 1'b1;
            pend_in   = pend_base - 1'b1;
            centre_in = recv_base;
         end
      end else begin
         push       = 1'b1;
         push_value = req_port.sample_in;
         emit       = (recv_base == CNT_MAX);
         if (recv_base != CNT_MAX) begin
            recv_in = recv_base + 1'b1;
         end
         if (pend_base != CNT_MAX) begin
            pend_in = pend_base + 1'b1;
         end
      end
      for (int i = 0; i < wsi_pkg::TAPS; i++) begin
         if (push) begin
            hist_in[i] = (i == 0) ? push_value : hist_base[(i == 0) ? 0 : i - 1];
         end else begin
            hist_in[i] = hist_base[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wsi_pkg::TAPS; i++) begin
            hist_ff[i] <= '0;
         end
         recv_ff <= '0;
         pend_ff <= '0;
      end else if (req_accept) begin
         hist_ff <= hist_in;
         recv_ff <= recv_in;
         pend_ff <= pend_in;
      end
   end

   // History tap for the current phase and tap; taps newer than the newest read zero.
   always_comb begin
      ofs = OFS_BITS'(centre_ff) + OFS_BITS'(wsi_pkg::HALF_TAPS) - OFS_BITS'(tap_ff);
      if (ofs < OFS_BITS'(wsi_pkg::TAPS)) begin
         tap_sample = hist_ff[ofs[wsi_pkg::TAP_BITS-1:0]];
      end else begin
         tap_sample = '0;
      end
   end

   assign issue.valid     = (state_ff == ST_ISSUE);
   assign issue.first     = (tap_ff == '0);
   assign issue.sample    = tap_sample;
   assign issue.coef_addr = {phase_ff, tap_ff};

   wsi_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .status (mac_status),
      .result (mac_result)
   );

   // Sequencer over phases and taps.
   assign rsp_load = (state_ff == ST_FINISH) && !mac_status.busy &&
                     (!rsp_valid_ff || rsp_port.ready);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      tap_in   = tap_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && emit) begin
               state_in = ST_ISSUE;
               phase_in = '0;
               tap_in   = '0;
            end
         end
         ST_ISSUE: begin
            tap_in = tap_ff + 1'b1;
            if (tap_ff == TAP_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               tap_in = '0;
               if (phase_ff == PHASE_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ISSUE;
                  phase_in = phase_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         tap_ff   <= tap_in;
      end
      if (req_accept) begin
         centre_ff <= centre_in;
      end
   end

   // Output register: holds a word until the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_value_ff <= mac_result;
         rsp_phase_ff <= phase_ff;
         rsp_last_ff  <= (phase_ff == PHASE_LAST);
      end
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.value_out  = rsp_value_ff;
   assign rsp_port.phase      = rsp_phase_ff;
   assign rsp_port.block_last = rsp_last_ff;

endmodule

### rtl/wsi_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit with coefficient ROM, rounding and saturation.
module wsi_mac (
   input  logic                                   clock,
   input  logic                                   reset,
   input  wsi_pkg::mac_issue_type                 issue,
   output wsi_pkg::mac_status_type                status,
   output logic signed [wsi_pkg::SAMPLE_BITS-1:0] result
);

   localparam int TAP_MASK = (1 << wsi_pkg::TAP_BITS) - 1;
   localparam logic signed [wsi_pkg::ACC_BITS-1:0] ROUND_HALF =
      wsi_pkg::ACC_BITS'(1 << (wsi_pkg::COEF_FRAC - 1));
   localparam logic signed [wsi_pkg::RND_BITS-1:0] SAT_MAX =
      wsi_pkg::RND_BITS'((1 << (wsi_pkg::SAMPLE_BITS - 1)) - 1);
   localparam logic signed [wsi_pkg::RND_BITS-1:0] SAT_MIN =
      -wsi_pkg::RND_BITS'(1 << (wsi_pkg::SAMPLE_BITS - 1));

   logic signed [wsi_pkg::COEF_BITS-1:0]   coef_rom [wsi_pkg::COEF_DEPTH];

   logic                                   s1_valid_ff;
   logic                                   s1_first_ff;
   logic signed [wsi_pkg::SAMPLE_BITS-1:0] s1_sample_ff;
   logic signed [wsi_pkg::COEF_BITS-1:0]   coef_ff;
   logic                                   s2_valid_ff;
   logic                                   s2_first_ff;
   logic signed [wsi_pkg::PROD_BITS-1:0]   prod_ff;
   logic signed [wsi_pkg::ACC_BITS-1:0]    acc_ff;
   logic signed [wsi_pkg::ACC_BITS-1:0]    acc_in;
   logic signed [wsi_pkg::ACC_BITS-1:0]    rnd_sum;
   logic signed [wsi_pkg::RND_BITS-1:0]    rounded;

   // Constant coefficient table, one entry per phase and tap code.
   for (genvar gi = 0; gi < wsi_pkg::COEF_DEPTH; gi++) begin : g_rom
      localparam logic signed [wsi_pkg::COEF_BITS-1:0] CVAL =
         wsi_pkg::coef_value(gi >> wsi_pkg::TAP_BITS, gi & TAP_MASK);
      assign coef_rom[gi] = CVAL;
   end

   // Stage one: registered ROM read alongside the sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue.valid;
      end
      s1_first_ff  <= issue.first;
      s1_sample_ff <= issue.sample;
      coef_ff      <= coef_rom[issue.coef_addr];
   end

   // Stage two: the product.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_first_ff <= s1_first_ff;
      prod_ff     <= s1_sample_ff * coef_ff;
   end

   // Stage three: accumulate; the first tap of a phase restarts the sum.
   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         if (s2_first_ff) begin
            acc_in = wsi_pkg::ACC_BITS'(prod_ff);
         end else begin
            acc_in = acc_ff + wsi_pkg::ACC_BITS'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Round the Q31 sum to Q15 and clamp to the sample range.
   always_comb begin
      rnd_sum = acc_ff + ROUND_HALF;
      rounded = rnd_sum[wsi_pkg::ACC_BITS-1:wsi_pkg::COEF_FRAC];
      if (rounded > SAT_MAX) begin
         result = SAT_MAX[wsi_pkg::SAMPLE_BITS-1:0];
      end else if (rounded < SAT_MIN) begin
         result = SAT_MIN[wsi_pkg::SAMPLE_BITS-1:0];
      end else begin
         result = rounded[wsi_pkg::SAMPLE_BITS-1:0];
      end
   end

   assign status.busy = s1_valid_ff | s2_valid_ff;

endmodule

### dv/tb_windowed_sinc_interpolator.sv
`timescale 1ns / 1ps
// Self-checking testbench of the windowed sinc interpolator with its own coefficient model.
module tb_windowed_sinc_interpolator;

   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int SETTLE_CYCLES    = 700;
   localparam int LONG_HOLD_AT     = 300;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WORD_TARGET      = 235;
   localparam logic [63:0] PI_FIX  = 64'd843314857;
   localparam logic [63:0] BETA_SQ = 64'd9;
   localparam longint SAT_HI = (longint'(1) <<< (wsi_pkg::SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO = -(longint'(1) <<< (wsi_pkg::SAMPLE_BITS - 1));
   localparam logic signed [wsi_pkg::SAMPLE_BITS-1:0] FULL_POS =
      {1'b0, {(wsi_pkg::SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [wsi_pkg::SAMPLE_BITS-1:0] FULL_NEG =
      {1'b1, {(wsi_pkg::SAMPLE_BITS-1){1'b0}}};

   typedef struct {
      logic signed [wsi_pkg::SAMPLE_BITS-1:0] sample;
      logic                                   start;
      logic                                   flush;
      logic                                   drain_first;
   } in_word_type;

   typedef struct {
      logic signed [wsi_pkg::SAMPLE_BITS-1:0] value;
      logic [wsi_pkg::PHASE_BITS-1:0]         phase;
      logic                                   last;
   } out_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsi_req_if req_bus();
   wsi_rsp_if rsp_bus();

   windowed_sinc_interpolator DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Coefficient table and interpolator state of the predictor.
   int sinc_taps [wsi_pkg::INTERP_FACTOR][wsi_pkg::TAPS];
   int tap_line [wsi_pkg::TAPS];
   int taken_count;
   int centres_due;

   in_word_type  sample_words [$];
   out_word_type predicted_outputs [$];
   in_word_type  offered;

   int words_total  = 0;
   int words_taken  = 0;
   int results_seen = 0;
   int mismatches   = 0;
   int send_wait    = 0;
   int send_calm    = 0;
   int recv_wait    = 0;
   int recv_calm    = 0;
   int idle_cycles  = 0;
   int plan_pending = 0;

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Kaiser window term: I0 of num/den in Q24 from 40 series terms.
   function automatic logic [63:0] bessel_i0_q24(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] term;
      logic [63:0] total;
      term  = 64'd1 << 24;
      total = term;
      for (int m = 1; m <= 40; m++) begin
         term  = term * num / (64'(m) * 64'(m) * den);
         total = total + term;
      end
      return total;
   endfunction

   // Sine of pi*p/16 in Q28, folded about pi/2 and built from 13 Taylor terms.
   function automatic logic [63:0] sine_pi_q28(input int p);
      int          q;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] term;
      logic [63:0] pos;
      logic [63:0] neg;
      q    = (p <= wsi_pkg::INTERP_FACTOR - p) ? p : (wsi_pkg::INTERP_FACTOR - p);
      a    = PI_FIX * 64'(q) / 64'(wsi_pkg::INTERP_FACTOR);
      a2   = (a * a) >> 28;
      term = a;
      pos  = a;
      neg  = 64'd0;
      for (int m = 1; m <= 12; m++) begin
         term = ((term * a2) >> 28) / (64'(2 * m) * 64'(2 * m + 1));
         if (m % 2 == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      return (pos > neg) ? (pos - neg) : 64'd0;
   endfunction

   // Windowed sinc coefficients in Q16, one row per phase.
   function automatic void build_taps();
      logic [63:0] hh;
      logic [63:0] i0_beta;
      logic [63:0] s;
      logic [63:0] kk;
      logic [63:0] w;
      logic [63:0] mag;
      logic [63:0] ad;
      logic [63:0] c;
      int          k;
      int          d;
      logic        flip;
      hh      = 64'(wsi_pkg::HALF_TAPS * wsi_pkg::HALF_TAPS);
      i0_beta = bessel_i0_q24(BETA_SQ * hh, hh);
      for (int p = 0; p < wsi_pkg::INTERP_FACTOR; p++) begin
         s = sine_pi_q28(p);
         for (int j = 0; j < wsi_pkg::TAPS; j++) begin
            k    = j - wsi_pkg::HALF_TAPS;
            kk   = 64'(k * k);
            w    = (bessel_i0_q24(BETA_SQ * (hh - kk), hh) << 28) / i0_beta;
            flip = 1'b0;
            if (p == 0) begin
               mag = (k == 0) ? (64'd1 << 28) : 64'd0;
            end else begin
               d    = p - k * wsi_pkg::INTERP_FACTOR;
               ad   = 64'((d < 0) ? -d : d);
               mag  = ((64'(wsi_pkg::INTERP_FACTOR) * s) << 28) / (PI_FIX * ad);
               flip = ((k % 2) != 0) != (k >= 1);
            end
            c = (w * mag + (64'd1 << 39)) >> 40;
            sinc_taps[p][j] = flip ? -int'(c) : int'(c);
         end
      end
   endfunction

   function automatic void clear_history();
      foreach (tap_line[i]) tap_line[i] = 0;
      taken_count = 0;
      centres_due = 0;
   endfunction

   function automatic void shift_in(input int x);
      for (int i = wsi_pkg::TAPS - 1; i > 0; i--) tap_line[i] = tap_line[i-1];
      tap_line[0] = x;
   endfunction

   // Sixteen phases of the centre at history offset d, rounded and saturated.
   function automatic void interpolate_centre(input int d);
      longint       acc;
      longint       r;
      int           o;
      out_word_type res;
      for (int p = 0; p < wsi_pkg::INTERP_FACTOR; p++) begin
         acc = 0;
         for (int j = 0; j < wsi_pkg::TAPS; j++) begin
            o = d + wsi_pkg::HALF_TAPS - j;
            if (o >= 0 && o < wsi_pkg::TAPS) begin
               acc += longint'(tap_line[o]) * longint'(sinc_taps[p][j]);
            end
         end
         r = (acc + 32768) >>> 16;
         if (r > SAT_HI) r = SAT_HI;
         if (r < SAT_LO) r = SAT_LO;
         res.value = r[wsi_pkg::SAMPLE_BITS-1:0];
         res.phase = wsi_pkg::PHASE_BITS'(p);
         res.last  = (p == wsi_pkg::INTERP_FACTOR - 1);
         predicted_outputs.insert(predicted_outputs.size(), res);
      end
   endfunction

   // Effect of one accepted word on the history, the counters and the results.
   function automatic void predict_word(input in_word_type w);
      if (w.start) clear_history();
      if (w.flush) begin
         if (centres_due == 0) return;
         shift_in(0);
         centres_due--;
         interpolate_centre(taken_count);
      end else begin
         shift_in(int'(w.sample));
         if (taken_count >= wsi_pkg::HALF_TAPS - 1) interpolate_centre(wsi_pkg::HALF_TAPS - 1);
         if (taken_count < wsi_pkg::HALF_TAPS - 1) taken_count++;
         if (centres_due < wsi_pkg::HALF_TAPS - 1) centres_due++;
      end
   endfunction

   // Idle cycles before the next word, with occasional runs of back-to-back traffic.
   function automatic int pick_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   function automatic logic signed [wsi_pkg::SAMPLE_BITS-1:0] sample_value();
      case ($urandom_range(0, 5))
         0: begin
            return FULL_POS;
         end
         1: begin
            return FULL_NEG;
         end
         2: begin
            return wsi_pkg::SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
         end
         default: begin
            return wsi_pkg::SAMPLE_BITS'($urandom());
         end
      endcase
   endfunction

   // Queues one word and tracks how many centres are left pending.
   function automatic void queue_word(input logic signed [wsi_pkg::SAMPLE_BITS-1:0] s,
                                      input logic st, input logic fl, input logic dr);
      in_word_type w;
      w.sample      = s;
      w.start       = st;
      w.flush       = fl;
      w.drain_first = dr;
      sample_words.insert(sample_words.size(), w);
      words_total++;
      if (st) plan_pending = 0;
      if (fl) begin
         if (plan_pending > 0) begin
            plan_pending--;
         end
      end else begin
         if (plan_pending < wsi_pkg::HALF_TAPS - 1) plan_pending++;
      end
   endfunction

   // Driver: offers queued words, predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.sample_in <= '0;
         req_bus.start_req <= 1'b0;
         req_bus.flush     <= 1'b0;
         send_wait = 0;
         clear_history();
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_word(offered);
            words_taken++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // Word still on offer: hold it.
         end else if (send_wait > 0) begin
            send_wait--;
            req_bus.valid <= 1'b0;
         end else if (sample_words.size() != 0 &&
                      (!sample_words[0].drain_first || predicted_outputs.size() == 0)) begin
            offered = sample_words.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.sample_in <= offered.sample;
            req_bus.start_req <= offered.start;
            req_bus.flush     <= offered.flush;
            send_wait = pick_wait(send_calm);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result word against the oldest prediction.
   always @(posedge clock) begin
      out_word_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("unexpected result: value_out %0d phase %0d block_last %0b",
                      rsp_bus.value_out, rsp_bus.phase, rsp_bus.block_last);
               mismatches++;
            end else begin
               want = predicted_outputs.pop_front();
               if (rsp_bus.value_out !== want.value) begin
                  $error("value_out: expected %0d, actual %0d", want.value, rsp_bus.value_out);
                  mismatches++;
               end
               if (rsp_bus.phase !== want.phase) begin
                  $error("phase: expected %0d, actual %0d", want.phase, rsp_bus.phase);
                  mismatches++;
               end
               if (rsp_bus.block_last !== want.last) begin
                  $error("block_last: expected %0b, actual %0b", want.last, rsp_bus.block_last);
                  mismatches++;
               end
            end
            results_seen++;
            // One long hold-off so that the block backs up into its input.
            if (results_seen == LONG_HOLD_AT) begin
               recv_wait = LONG_HOLD_CYCLES;
            end else begin
               recv_wait = pick_wait(recv_calm);
            end
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_windowed_sinc_interpolator: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus plan, reset and end of run.
   initial begin
      int   kind;
      int   len;
      int   n_flush;
      logic drain;
      logic first;
      req_bus.valid     = 1'b0;
      req_bus.sample_in = '0;
      req_bus.start_req = 1'b0;
      req_bus.flush     = 1'b0;
      rsp_bus.ready     = 1'b0;
      build_taps();

      // Flush with nothing pending, then start together with flush.
      queue_word(16'sd0, 1'b0, 1'b1, 1'b0);
      queue_word(FULL_POS, 1'b1, 1'b1, 1'b0);
      // Stream shorter than the half window, drained by flushes plus one extra.
      queue_word(FULL_POS, 1'b1, 1'b0, 1'b0);
      queue_word(FULL_NEG, 1'b0, 1'b0, 1'b0);
      queue_word(16'sd0, 1'b0, 1'b0, 1'b0);
      repeat (4) queue_word(16'sd77, 1'b0, 1'b1, 1'b0);
      // A sample after the flushes continues the old stream.
      queue_word(16'sd1234, 1'b0, 1'b0, 1'b0);
      // Full-scale samples matched to the mid-phase signs drive the output into saturation.
      for (int k = 0; k < wsi_pkg::HALF_TAPS; k++) begin
         queue_word((sinc_taps[wsi_pkg::INTERP_FACTOR/2][wsi_pkg::HALF_TAPS+k] >= 0) ?
                    FULL_POS : FULL_NEG, k == 0, 1'b0, 1'b0);
      end

      // Random part: mostly started streams drained by flushes, some noise.
      first = 1'b1;
      while (words_total < WORD_TARGET) begin
         kind  = $urandom_range(0, 9);
         drain = first || ($urandom_range(0, 5) == 0);
         first = 1'b0;
         if (kind <= 6) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
               queue_word(sample_value(), i == 0, 1'b0, drain && i == 0);
            end
            n_flush = ($urandom_range(0, 3) == 0) ? $urandom_range(0, wsi_pkg::HALF_TAPS + 2)
                                                  : plan_pending;
            for (int i = 0; i < n_flush; i++) begin
               queue_word(sample_value(), 1'b0, 1'b1, 1'b0);
            end
         end else if (kind == 7) begin
            // The stream goes on without a fresh start.
            len = $urandom_range(1, 20);
            for (int i = 0; i < len; i++) begin
               queue_word(sample_value(), 1'b0, 1'b0, drain && i == 0);
            end
         end else begin
            queue_word(sample_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       drain);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (words_taken != words_total || predicted_outputs.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb_windowed_sinc_interpolator: clean");
      end else begin
         $display("tb_windowed_sinc_interpolator: errors");
      end
      $finish;
   end

endmodule
